/* src/modular_exponentiation_defines.svh */
// assertion macros for the modular exponentiation block
// included by the top level; no other dependencies
`ifndef MODULAR_EXPONENTIATION_DEFINES_SVH
`define MODULAR_EXPONENTIATION_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MODEXP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("modexp assertion failed");

// next-cycle implication, disabled during reset
`define MODEXP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("modexp assertion failed");

`endif

/* src/modexp_pkg.sv */
// shared types and constants of the modular exponentiation block
// no dependencies
`timescale 1ns / 1ps

package modexp_pkg;

    localparam int FIELD_WIDTH     = 64;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MODULUS  = 1'b0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_EXPONENT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_CHECK,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_status;

endpackage

/* src/modexp_if.sv */
// valid/ready stream interfaces for the base and result words
// depends on modexp_pkg for the field width
`timescale 1ns / 1ps

interface modexp_base_if;
    logic                               valid;
    logic                               ready;
    logic [modexp_pkg::FIELD_WIDTH-1:0] base_value;

    modport source (output valid, output base_value, input ready);
    modport sink   (input valid, input base_value, output ready);
endinterface

interface modexp_result_if;
    logic                               valid;
    logic                               ready;
    logic [modexp_pkg::FIELD_WIDTH-1:0] power_result;

    modport source (output valid, output power_result, input ready);
    modport sink   (input valid, input power_result, output ready);
endinterface

/* src/modexp_mulmod.sv */
// shift-add modular multiplier, one multiplier bit per cycle, msb first
// depends on modexp_pkg for the status struct
`timescale 1ns / 1ps

module modexp_mulmod #(
    parameter int W = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [W-1:0]            i_a,
    input  logic [W-1:0]            i_y,
    input  logic [W-1:0]            i_m,
    output modexp_pkg::t_mul_status o_status,
    output logic [W-1:0]            o_product
);

    localparam int CW = $clog2(W);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_a;
    logic [W-1:0]  r_y;
    logic [W-1:0]  r_p;

    logic [W+1:0]  sum;
    logic [W+1:0]  m_one;
    logic [W+1:0]  m_two;
    logic [W-1:0]  n_p;

    // 2p + bit*y, then bring back below m (wrap at W bits when m is zero)
    always_comb begin
        sum   = {1'b0, r_p, 1'b0} + (r_a[W-1] ? {2'b00, r_y} : '0);
        m_one = {2'b00, i_m};
        m_two = {1'b0, i_m, 1'b0};
        if (i_m == '0) begin
            n_p = sum[W-1:0];
        end else if (sum >= m_two) begin
            n_p = W'(sum - m_two);
        end else if (sum >= m_one) begin
            n_p = W'(sum - m_one);
        end else begin
            n_p = sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_y   <= i_y;
            r_p   <= '0;
            r_cnt <= CW'(W - 1);
        end else if (r_busy) begin
            r_a   <= {r_a[W-2:0], 1'b0};
            r_p   <= n_p;
            r_cnt <= r_cnt - 1'b1;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_product     = r_p;

endmodule

/* src/modular_exponentiation.sv */
// top level: base^exponent mod modulus, right-to-left square and multiply
// depends on modexp_pkg, modexp_if, modexp_mulmod and the assertion header
//
// usage:
//   i_base carries one base word per handshake; o_result returns one word each.
//   i_cfg_we / i_cfg_index / i_cfg_data write modulus (index 0) and exponent
//   (index 1); write them only while the block is idle.
//   one base is processed at a time; i_base.ready is high only when idle.
//   with a nonzero modulus the base is first reduced modulo the modulus;
//   then each exponent bit up to the highest set one takes a check step,
//   a multiply when the bit is set and a square, all on the single
//   shift-add multiplier, one bit per cycle; W = OPERAND_WIDTH.
//   exponent zero returns 1; modulus zero wraps the products at W bits.
//   the result sits in an output register; a new base is accepted while it
//   waits, but the next result is held until the receiver takes the first.
//   reset (synchronous, active low) sets modulus 2, exponent 0 and idles.
`timescale 1ns / 1ps
`include "modular_exponentiation_defines.svh"

module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    modexp_base_if.sink                            i_base,
    modexp_result_if.source                        o_result,
    input  logic                                   i_cfg_we,
    input  logic [modexp_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [modexp_pkg::FIELD_WIDTH-1:0]     i_cfg_data
);

    localparam int W = OPERAND_WIDTH;

    modexp_pkg::t_state      r_state;
    modexp_pkg::t_state      n_state;
    logic [W-1:0]            r_modulus;
    logic [W-1:0]            r_exponent;
    logic [W-1:0]            r_e;
    logic [W-1:0]            r_b;
    logic [W-1:0]            r_acc;
    logic                    r_out_valid;
    logic [modexp_pkg::FIELD_WIDTH-1:0] r_out_data;

    logic                    wrap;
    logic                    in_fire;
    logic                    out_free;
    logic                    in_ready;
    logic                    ld_out;
    logic                    mul_start;
    logic [W-1:0]            mul_a;
    logic [W-1:0]            mul_y;
    logic [W-1:0]            mul_p;
    modexp_pkg::t_mul_status mul_status;
    logic [W-1:0]            base_in;
    logic                    in_work;
    logic                    in_check;
    logic                    sqr_done;

    assign base_in  = i_base.base_value[W-1:0];
    assign wrap     = (r_modulus == '0);
    assign in_fire  = i_base.valid && in_ready;
    assign out_free = !r_out_valid || o_result.ready;

    modexp_mulmod #(
        .W (W)
    ) u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_a       (mul_a),
        .i_y       (mul_y),
        .i_m       (r_modulus),
        .o_status  (mul_status),
        .o_product (mul_p)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            modexp_pkg::ST_IDLE: begin
                if (in_fire) begin
                    n_state = wrap ? modexp_pkg::ST_CHECK : modexp_pkg::ST_REDUCE;
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (mul_status.done) begin
                    n_state = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_CHECK: begin
                if (r_e == '0) begin
                    n_state = modexp_pkg::ST_FINISH;
                end else if (r_e[0]) begin
                    n_state = modexp_pkg::ST_MUL;
                end else begin
                    n_state = modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_MUL: begin
                if (mul_status.done) begin
                    n_state = modexp_pkg::ST_SQR;
                end
            end
            modexp_pkg::ST_SQR: begin
                if (mul_status.done) begin
                    n_state = modexp_pkg::ST_CHECK;
                end
            end
            modexp_pkg::ST_FINISH: begin
                if (out_free) begin
                    n_state = modexp_pkg::ST_IDLE;
                end
            end
            default: n_state = modexp_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        in_ready  = 1'b0;
        ld_out    = 1'b0;
        mul_start = 1'b0;
        mul_a     = r_b;
        mul_y     = r_b;
        unique case (r_state)
            modexp_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (i_base.valid && !wrap) begin
                    mul_start = 1'b1;
                    mul_a     = base_in;
                    mul_y     = W'(1);
                end
            end
            modexp_pkg::ST_CHECK: begin
                if (r_e != '0) begin
                    mul_start = 1'b1;
                    if (r_e[0]) begin
                        mul_a = r_acc;
                    end
                end
            end
            modexp_pkg::ST_MUL: begin
                mul_start = mul_status.done;
            end
            modexp_pkg::ST_FINISH: begin
                ld_out = out_free;
            end
            modexp_pkg::ST_REDUCE, modexp_pkg::ST_SQR: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= modexp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= W'(2);
            r_exponent <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                modexp_pkg::CFG_MODULUS:  r_modulus  <= i_cfg_data[W-1:0];
                modexp_pkg::CFG_EXPONENT: r_exponent <= i_cfg_data[W-1:0];
                default: begin
                end
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            modexp_pkg::ST_IDLE: begin
                if (in_fire) begin
                    r_e   <= r_exponent;
                    r_acc <= W'(1);
                    r_b   <= base_in;
                end
            end
            modexp_pkg::ST_REDUCE: begin
                if (mul_status.done) begin
                    r_b <= mul_p;
                end
            end
            modexp_pkg::ST_MUL: begin
                if (mul_status.done) begin
                    r_acc <= mul_p;
                end
            end
            modexp_pkg::ST_SQR: begin
                if (mul_status.done) begin
                    r_b <= mul_p;
                    r_e <= r_e >> 1;
                end
            end
            default: begin
            end
        endcase
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_data <= modexp_pkg::FIELD_WIDTH'(r_acc);
        end
    end

    assign i_base.ready          = in_ready;
    assign o_result.valid        = r_out_valid;
    assign o_result.power_result = r_out_data;

    assign in_work  = (r_state == modexp_pkg::ST_REDUCE) || (r_state == modexp_pkg::ST_MUL) ||
                      (r_state == modexp_pkg::ST_SQR);
    assign in_check = (r_state == modexp_pkg::ST_CHECK);
    assign sqr_done = (r_state == modexp_pkg::ST_SQR) && mul_status.done;

    `MODEXP_ASSERT_IMPLY(a_done_in_work, i_clk, i_rst_n, mul_status.done, in_work)
    `MODEXP_ASSERT_IMPLY(a_start_when_free, i_clk, i_rst_n, mul_start, !mul_status.busy)
    `MODEXP_ASSERT_NEXT(a_sqr_shifts_exp, i_clk, i_rst_n, sqr_done, (in_check && r_e == ($past(r_e) >> 1)))
    `MODEXP_ASSERT_IMPLY(a_base_reduced, i_clk, i_rst_n, (in_check && !wrap), (r_b < r_modulus))

endmodule
